// File: src/counting_semaphore_with_waiters_macros.svh
// Assertion macros for the counting semaphore block.
`ifndef COUNTING_SEMAPHORE_WITH_WAITERS_MACROS_SVH
`define COUNTING_SEMAPHORE_WITH_WAITERS_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define CSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSW_ASSERT(lbl, prop, msg)
`define CSW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: src/csw_pkg.sv
// Shared constants, types and codes of the counting semaphore block.
`timescale 1ns / 1ps

package csw_pkg;

  localparam int WAITER_DEPTH = 16;
  localparam int ID_WIDTH     = 8;

  // Width of the tag ports and of the permit count.
  localparam int TagW   = 8;
  localparam int CountW = 8;
  // Id bits that survive the tag port width.
  localparam int IdKeep = (ID_WIDTH < TagW) ? ID_WIDTH : TagW;
  localparam int DepthW = $clog2(WAITER_DEPTH + 1);

  typedef logic [IdKeep-1:0] waiter_id_t;

  typedef enum logic [2:0] {
    OUT_GRANTED  = 3'd0,
    OUT_QUEUED   = 3'd1,
    OUT_RESUMED  = 3'd2,
    OUT_REL_DONE = 3'd3,
    OUT_REJECTED = 3'd4
  } outcome_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_INIT_CNT = 1'b1
  } reg_index_t;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  // Shift control broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// File: src/csw_cell.sv
// One stack cell: holds a waiter id and shifts it toward or away from the top.
`timescale 1ns / 1ps

module csw_cell import csw_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  waiter_id_t up_id,
  input  waiter_id_t down_id,
  output waiter_id_t id
);

  waiter_id_t id_next;

  always_comb begin
    id_next = id;
    if (ctl.push) begin
      id_next = up_id;
    end else if (ctl.pop) begin
      id_next = down_id;
    end
  end

  always_ff @(posedge clk) begin
    id <= id_next;
  end

endmodule

// File: src/csw_stack.sv
// Waiter stack built as a row of shifting cells; cell 0 is the top.
`timescale 1ns / 1ps

module csw_stack import csw_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  waiter_id_t push_id,
  output waiter_id_t top_id
);

  waiter_id_t cell_id [WAITER_DEPTH];

  for (genvar i = 0; i < WAITER_DEPTH; i++) begin : g_cell
    waiter_id_t up_id;
    waiter_id_t down_id;

    if (i == 0) begin : g_first
      assign up_id = push_id;
    end else begin : g_mid_up
      assign up_id = cell_id[i-1];
    end

    // Bottom cell refills with its own value on a pop; depth tracking never reads it.
    if (i == WAITER_DEPTH - 1) begin : g_last
      assign down_id = cell_id[i];
    end else begin : g_mid_down
      assign down_id = cell_id[i+1];
    end

    csw_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .up_id   (up_id),
      .down_id (down_id),
      .id      (cell_id[i])
    );
  end

  assign top_id = cell_id[0];

endmodule

// File: src/counting_semaphore_with_waiters.sv
// Top level of the counting semaphore with a last-in first-out waiter stack.
// Usage:
//  - Input channel (in_valid/in_ready) carries mode, requester_id and
//    release_amount. mode 0 acquires one permit, mode 1 releases permits.
//  - Output channel (out_valid/out_ready) carries one result item per grant,
//    queue, resume, done or reject; last marks the final item of an input.
//  - Config port: cfg_we writes cfg_data to register cfg_index at once
//    (0 capacity, 1 initial count, which loads the count clamped to capacity).
//  - Results: the first result is registered after acceptance; a release that
//    resumes waiters first enters the resume state. Such a release then gives
//    one item a cycle while the receiver keeps up, one per resumed waiter until
//    the waiters or permits run out; every other input gives exactly one item.
//  - Throughput: one input per cycle for acquires and plain releases while the
//    receiver keeps up; a release busy resuming waiters holds in_ready low until
//    its last item. Pops wait for a free result register; each shifts every cell.
//  - The result register lets a new input in while an item waits, as long
//    as the receiver takes the waiting item in the same cycle.
//  - Reset: capacity 1, count 0, stack empty; no clearing pass is needed.
//  - Receiver stall: the result item holds and no input or resume advances until taken.
`timescale 1ns / 1ps

`include "counting_semaphore_with_waiters_macros.svh"

module counting_semaphore_with_waiters import csw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CountW-1:0] cfg_data,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [TagW-1:0]   requester_id,
  input  logic [CountW-1:0] release_amount,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TagW-1:0]   granted_id,
  output logic [2:0]        outcome,
  output logic              over_capacity,
  output logic [CountW-1:0] permits_left,
  output logic              last
);

  state_t            state, state_next;
  logic [CountW-1:0] capacity;
  logic [CountW-1:0] permit_count, permit_count_next;
  logic [DepthW-1:0] depth, depth_next;
  logic              over, over_next;

  logic              out_valid_next;
  logic [TagW-1:0]   granted_id_next;
  outcome_t          outcome_next;
  logic              over_capacity_next;
  logic              last_next;

  logic [CountW-1:0] eff_cap;
  logic [CountW:0]   sum;
  logic              sum_over;
  logic [CountW-1:0] rel_count;
  logic              slot_free;   // result register free this cycle
  logic              in_fire;
  logic              pop_fire;
  logic              pop_last;
  logic [DepthW-1:0] depth_dec;
  logic [CountW-1:0] count_dec;
  waiter_id_t        in_id;
  waiter_id_t        top_id;
  cell_ctl_t         stack_ctl;

  // A capacity of zero behaves as one.
  assign eff_cap   = (capacity == '0) ? CountW'(1) : capacity;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign pop_fire  = (state == S_POP) && slot_free;

  assign in_id     = requester_id[IdKeep-1:0];
  assign sum       = {1'b0, permit_count} + {1'b0, release_amount};
  assign sum_over  = sum > {1'b0, eff_cap};
  assign rel_count = sum_over ? eff_cap : sum[CountW-1:0];

  assign depth_dec = depth - DepthW'(1);
  assign count_dec = permit_count - CountW'(1);
  assign pop_last  = (depth_dec == '0) || (count_dec == '0);

  always_comb begin
    state_next         = state;
    permit_count_next  = permit_count;
    depth_next         = depth;
    over_next          = over;
    out_valid_next     = out_valid && !out_ready;
    granted_id_next    = granted_id;
    outcome_next       = outcome_t'(outcome);
    over_capacity_next = over_capacity;
    last_next          = last;
    stack_ctl          = '0;

    if (in_fire) begin
      out_valid_next     = 1'b1;
      over_capacity_next = 1'b0;
      last_next          = 1'b1;
      if (!mode) begin
        granted_id_next = TagW'(in_id);
        if (permit_count != '0) begin
          // Permit available: grant at once.
          permit_count_next = count_dec;
          outcome_next      = OUT_GRANTED;
        end else if (depth < DepthW'(WAITER_DEPTH)) begin
          // No permit: park the requester on the stack.
          stack_ctl.push = 1'b1;
          depth_next     = depth + DepthW'(1);
          outcome_next   = OUT_QUEUED;
        end else begin
          outcome_next = OUT_REJECTED;
        end
      end else if (release_amount == '0) begin
        granted_id_next = '0;
        outcome_next    = OUT_REJECTED;
      end else begin
        permit_count_next = rel_count;
        over_next         = sum_over;
        if (depth != '0) begin
          // Waiters present and the count is at least one: start resuming.
          out_valid_next = 1'b0;
          state_next     = S_POP;
        end else begin
          granted_id_next    = '0;
          outcome_next       = OUT_REL_DONE;
          over_capacity_next = sum_over;
        end
      end
    end else if (pop_fire) begin
      // Resume the newest waiter, one a cycle while the result register is free.
      stack_ctl.pop      = 1'b1;
      depth_next         = depth_dec;
      permit_count_next  = count_dec;
      out_valid_next     = 1'b1;
      granted_id_next    = TagW'(top_id);
      outcome_next       = OUT_RESUMED;
      over_capacity_next = over;
      last_next          = pop_last;
      if (pop_last) begin
        state_next = S_IDLE;
      end
    end

    // The user must write configuration only while idle; the block does not enforce it.
    if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CAPACITY: begin
          if (permit_count > ((cfg_data == '0) ? CountW'(1) : cfg_data)) begin
            permit_count_next = (cfg_data == '0) ? CountW'(1) : cfg_data;
          end
        end
        REG_INIT_CNT: begin
          permit_count_next = (cfg_data > eff_cap) ? eff_cap : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      capacity     <= CountW'(1);
      permit_count <= '0;
      depth        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      permit_count <= permit_count_next;
      depth        <= depth_next;
      out_valid    <= out_valid_next;
      if (cfg_we && (reg_index_t'(cfg_index) == REG_CAPACITY)) begin
        capacity <= cfg_data;
      end
    end
  end

  // Result payload and the overflow flag of the running release.
  always_ff @(posedge clk) begin
    over          <= over_next;
    granted_id    <= granted_id_next;
    outcome       <= outcome_next;
    over_capacity <= over_capacity_next;
    last          <= last_next;
  end

  assign permits_left = permit_count;

  csw_stack u_stack (
    .clk     (clk),
    .ctl     (stack_ctl),
    .push_id (in_id),
    .top_id  (top_id)
  );

  `CSW_ASSERT(a_depth_bound, depth <= DepthW'(WAITER_DEPTH), "waiter depth above stack size")
  `CSW_ASSERT(a_count_bound, permit_count <= eff_cap, "permit count above capacity")
  `CSW_ASSERT(a_pop_has_work, (state == S_POP) |-> (depth != '0 && permit_count != '0), "resume with no waiter or permit")
  `CSW_ASSERT(a_last_ends_pop, (pop_fire && pop_last) |=> (state == S_IDLE && out_valid && last), "final resume did not end the release")
  `CSW_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && depth == '0 && state == S_IDLE), "reset left state behind")

endmodule
